// ----- rtl/core/gamepad_event_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// gamepad_event_encoder_assert.svh
// Assertion macros used by the gamepad event encoder RTL. They expect the
// clock i_clk and the active-low reset i_rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_EVENT_ENCODER_ASSERT_SVH
`define GAMEPAD_EVENT_ENCODER_ASSERT_SVH

// same-cycle implication
`define GEE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gamepad event encoder: same-cycle check failed");

// next-cycle implication
`define GEE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gamepad event encoder: next-cycle check failed");

`endif

// ----- rtl/core/gee_pkg.sv -----
// ----------------------------------------------------------------------------
// gee_pkg
// Types and constants of the gamepad event encoder: sample and event
// payloads, configuration set, event kinds and register map.
// ----------------------------------------------------------------------------
package gee_pkg;

    // widths fixed by the sample and event formats
    localparam int BTN_W     = 16;
    localparam int BTN_IDX_W = 4;
    localparam int STICK_W   = 8;
    localparam int KIND_W    = 3;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 4;

    // default number of buttons taking part in the scan
    localparam int BUTTON_COUNT_DEF = 16;

    // upper six bits of a stick value count as movement
    localparam logic [STICK_W-1:0] STICK_MASK = 8'hFC;

    // event kinds
    localparam logic [KIND_W-1:0] EV_ANNOUNCE = 3'd0;
    localparam logic [KIND_W-1:0] EV_PUSH     = 3'd1;
    localparam logic [KIND_W-1:0] EV_RELEASE  = 3'd2;
    localparam logic [KIND_W-1:0] EV_NONE     = 3'd3;
    localparam logic [KIND_W-1:0] EV_STICK    = 3'd4;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ENABLED_BUTTONS     = 2'd0;
    localparam logic [1:0] REG_STICKS_ENABLED      = 2'd1;
    localparam logic [1:0] REG_STICKS_EVERY_SAMPLE = 2'd2;

    // reset values
    localparam logic [BTN_W-1:0] ENABLED_BUTTONS_RST = 16'hFFFF;

    typedef struct packed {
        logic [BTN_W-1:0]   button_bits;
        logic [STICK_W-1:0] left_x;
        logic [STICK_W-1:0] left_y;
        logic [STICK_W-1:0] right_x;
        logic [STICK_W-1:0] right_y;
        logic               poll_tick;
        logic               analog_tick;
    } t_sample;

    typedef struct packed {
        logic [KIND_W-1:0]    event_kind;
        logic [BTN_IDX_W-1:0] button_index;
        logic [STICK_W-1:0]   out_left_x;
        logic [STICK_W-1:0]   out_left_y;
        logic [STICK_W-1:0]   out_right_x;
        logic [STICK_W-1:0]   out_right_y;
        logic                 last_of_run;
    } t_event;

    typedef struct packed {
        logic [BTN_W-1:0] enabled_buttons;
        logic             sticks_enabled;
        logic             sticks_every_sample;
    } t_cfg;

endpackage

// ----- rtl/core/gee_if.sv -----
// ----------------------------------------------------------------------------
// gee_if
// Valid/ready channels of the gamepad event encoder: sample in, event out.
// ----------------------------------------------------------------------------
interface gee_sample_if;
    logic              valid;
    logic              ready;
    gee_pkg::t_sample  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gee_event_if;
    logic             valid;
    logic             ready;
    gee_pkg::t_event  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/gee_apb_regs.sv -----
// ----------------------------------------------------------------------------
// gee_apb_regs
// APB register file: button enable mask, stick enable, stick every-sample.
// Writes land on the access phase; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module gee_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gee_pkg::PADDR_W-1:0]  paddr,
    input  logic [gee_pkg::APB_DW-1:0]   pwdata,
    output logic [gee_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output gee_pkg::t_cfg                o_cfg
);

    gee_pkg::t_cfg r_cfg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled_buttons     <= gee_pkg::ENABLED_BUTTONS_RST;
            r_cfg.sticks_enabled      <= 1'b1;
            r_cfg.sticks_every_sample <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                gee_pkg::REG_ENABLED_BUTTONS:
                    r_cfg.enabled_buttons <= pwdata[gee_pkg::BTN_W-1:0];
                gee_pkg::REG_STICKS_ENABLED:
                    r_cfg.sticks_enabled <= pwdata[0];
                gee_pkg::REG_STICKS_EVERY_SAMPLE:
                    r_cfg.sticks_every_sample <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            gee_pkg::REG_ENABLED_BUTTONS:
                prdata = {{(gee_pkg::APB_DW-gee_pkg::BTN_W){1'b0}}, r_cfg.enabled_buttons};
            gee_pkg::REG_STICKS_ENABLED:
                prdata = {{(gee_pkg::APB_DW-1){1'b0}}, r_cfg.sticks_enabled};
            gee_pkg::REG_STICKS_EVERY_SAMPLE:
                prdata = {{(gee_pkg::APB_DW-1){1'b0}}, r_cfg.sticks_every_sample};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/gamepad_event_encoder.sv -----
// ----------------------------------------------------------------------------
// gamepad_event_encoder
// Turns gamepad samples into a run of announce, button, no-button and stick
// events, the button events coming from a bit-serial button scan.
// ----------------------------------------------------------------------------
// Usage:
//   i_smp  : one sample per request (buttons, four stick axes, poll/analog ticks).
//            Ready only while the sequencer is idle.
//   o_evt  : events, last_of_run set on the final event of a sample. A sample
//            may give no events at all.
//   APB    : enabled_buttons at 0x0, sticks_enabled at 0x4,
//            sticks_every_sample at 0x8. Write only while idle.
// Sequence: a sample is taken in idle; the state register then steps through
//   the announce, scan, no-button and stick states as needed, and each event
//   state loads its event into the output register. The scan shifts the button
//   event mask one bit a cycle from button 0 while the output register is not
//   held, and stops after the highest button with an event. The sequencer is
//   back to ready the cycle after its last event is produced.
// Stall: while the output register is held, the sequencer waits; nothing is
//   dropped. The last event may still wait while the next sample is taken.
// Reset: synchronous, active low; clears state, counter and pending flags and
//   loads register defaults (all buttons on, sticks on, tick-paced sticks).
// ----------------------------------------------------------------------------
`include "gamepad_event_encoder_assert.svh"

module gamepad_event_encoder #(
    parameter int BUTTON_COUNT = gee_pkg::BUTTON_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gee_sample_if.sink                   i_smp,
    gee_event_if.source                  o_evt,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gee_pkg::PADDR_W-1:0]  paddr,
    input  logic [gee_pkg::APB_DW-1:0]   pwdata,
    output logic [gee_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int SCAN_LEN = (BUTTON_COUNT >= gee_pkg::BTN_W) ? gee_pkg::BTN_W : BUTTON_COUNT;
    localparam logic [gee_pkg::BTN_W-1:0] ACTIVE_MASK =
        gee_pkg::BTN_W'((33'd1 << SCAN_LEN) - 33'd1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ANN   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_NONE  = 5'b01000,
        S_STICK = 5'b10000
    } t_state;

    gee_pkg::t_cfg cfg;

    gee_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // persistent state
    logic [gee_pkg::BTN_W-1:0]          r_prev_btn;
    logic [3:0][gee_pkg::STICK_W-1:0]   r_prev_sticks;
    logic                               r_dpoll;
    logic                               r_apoll;
    logic                               r_due;
    logic [7:0]                         r_ann_cnt;

    // sequencer
    t_state                             r_state;
    t_state                             n_state;
    logic [gee_pkg::BTN_W-1:0]          r_emit;
    logic [gee_pkg::BTN_W-1:0]          r_level;
    logic [gee_pkg::BTN_IDX_W-1:0]      r_idx;
    logic                               r_do_none;
    logic                               r_do_stick;

    // output register
    logic                               r_out_valid;
    gee_pkg::t_event                    r_out;
    gee_pkg::t_event                    n_out;
    logic                               produce;

    // sample decode
    gee_pkg::t_sample                   smp;
    logic                               accept;
    logic                               adv;
    logic [gee_pkg::BTN_W-1:0]          btn;
    logic                               dpoll;
    logic                               apoll;
    logic                               due;
    logic                               scan_run;
    logic [gee_pkg::BTN_W-1:0]          emit;
    logic                               do_ann;
    logic                               do_none;
    logic                               stick_chk;
    logic                               moved;
    logic                               do_stick;
    logic                               has_events;
    logic [3:0][gee_pkg::STICK_W-1:0]   sticks;
    t_state                             first_state;
    t_state                             after_scan;
    t_state                             after_ann;
    t_state                             after_none;
    logic                               scan_done;

    assign smp         = i_smp.data;
    assign i_smp.ready = (r_state == S_IDLE);
    assign accept      = i_smp.valid && i_smp.ready;
    assign adv         = !r_out_valid || o_evt.ready;

    // decisions for a new sample
    always_comb begin
        sticks    = {smp.right_y, smp.right_x, smp.left_y, smp.left_x};
        btn       = smp.button_bits & cfg.enabled_buttons & ACTIVE_MASK;
        dpoll     = r_dpoll || smp.poll_tick;
        apoll     = r_apoll || smp.poll_tick;
        due       = r_due || smp.analog_tick;
        scan_run  = (btn != r_prev_btn) || dpoll;
        emit      = scan_run ? ((btn ^ r_prev_btn) | (dpoll ? btn : '0)) : '0;
        do_ann    = (r_ann_cnt == 8'd0);
        do_none   = scan_run && (btn == '0);
        stick_chk = cfg.sticks_enabled && (due || cfg.sticks_every_sample);
        moved     = apoll;
        for (int k = 0; k < 4; k++) begin
            if ((sticks[k] & gee_pkg::STICK_MASK) !=
                (r_prev_sticks[k] & gee_pkg::STICK_MASK)) begin
                moved = 1'b1;
            end
        end
        do_stick  = stick_chk && moved;
        priority if (do_ann)       first_state = S_ANN;
        else if (emit != '0)       first_state = S_SCAN;
        else if (do_none)          first_state = S_NONE;
        else if (do_stick)         first_state = S_STICK;
        else                       first_state = S_IDLE;
    end

    assign has_events = do_ann || (emit != '0) || do_none || do_stick;

    // follow-on states from the stored run flags
    always_comb begin
        after_none = r_do_stick ? S_STICK : S_IDLE;
        after_scan = r_do_none ? S_NONE : after_none;
        after_ann  = (r_emit != '0) ? S_SCAN : after_scan;
        scan_done  = ((r_emit >> 1) == '0);
    end

    // event generation, one step per advance
    always_comb begin
        n_state = r_state;
        produce = 1'b0;
        n_out   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = first_state;
                end
            end
            S_ANN: begin
                if (adv) begin
                    produce          = 1'b1;
                    n_out.event_kind = gee_pkg::EV_ANNOUNCE;
                    n_out.last_of_run = (after_ann == S_IDLE);
                    n_state          = after_ann;
                end
            end
            S_SCAN: begin
                if (adv) begin
                    produce            = r_emit[0];
                    n_out.event_kind   = r_level[0] ? gee_pkg::EV_PUSH : gee_pkg::EV_RELEASE;
                    n_out.button_index = r_idx;
                    n_out.last_of_run  = scan_done && (after_scan == S_IDLE);
                    if (scan_done) begin
                        n_state = after_scan;
                    end
                end
            end
            S_NONE: begin
                if (adv) begin
                    produce           = 1'b1;
                    n_out.event_kind  = gee_pkg::EV_NONE;
                    n_out.last_of_run = (after_none == S_IDLE);
                    n_state           = after_none;
                end
            end
            S_STICK: begin
                if (adv) begin
                    produce           = 1'b1;
                    n_out.event_kind  = gee_pkg::EV_STICK;
                    n_out.out_left_x  = r_prev_sticks[0];
                    n_out.out_left_y  = r_prev_sticks[1];
                    n_out.out_right_x = r_prev_sticks[2];
                    n_out.out_right_y = r_prev_sticks[3];
                    n_out.last_of_run = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_prev_btn    <= '0;
            r_prev_sticks <= '0;
            r_dpoll       <= 1'b0;
            r_apoll       <= 1'b0;
            r_due         <= 1'b0;
            r_ann_cnt     <= '0;
            r_do_none     <= 1'b0;
            r_do_stick    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_ann_cnt  <= r_ann_cnt + 8'd1;
                r_do_none  <= do_none;
                r_do_stick <= do_stick;
                if (scan_run) begin
                    r_prev_btn <= btn;
                    r_dpoll    <= 1'b0;
                end else begin
                    r_dpoll    <= dpoll;
                end
                if (stick_chk) begin
                    r_due   <= 1'b0;
                    r_apoll <= 1'b0;
                end else begin
                    r_due   <= due;
                    r_apoll <= apoll;
                end
                if (do_stick) begin
                    r_prev_sticks <= sticks;
                end
            end
        end
    end

    // scan shifter and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_emit  <= emit;
            r_level <= btn;
            r_idx   <= '0;
        end else if (r_state == S_SCAN && adv) begin
            r_emit  <= r_emit >> 1;
            r_level <= r_level >> 1;
            r_idx   <= r_idx + 1'b1;
        end
        if (produce) begin
            r_out <= n_out;
        end
    end

    assign o_evt.valid = r_out_valid;
    assign o_evt.data  = r_out;

    // checks
    `GEE_ASSERT_NOW(a_scan_has_work, r_state == S_SCAN, r_emit != '0)
    `GEE_ASSERT_NEXT(a_run_starts, accept && has_events, r_state != S_IDLE)
    `GEE_ASSERT_NOW(a_stick_is_last, o_evt.valid && o_evt.data.event_kind == gee_pkg::EV_STICK, o_evt.data.last_of_run)

endmodule
